// ----- src/moving_window_mean_range_filter_macros.svh -----
// Assertion macros used by the checker file.
`ifndef MOVING_WINDOW_MEAN_RANGE_FILTER_MACROS_SVH
`define MOVING_WINDOW_MEAN_RANGE_FILTER_MACROS_SVH

// Check that the consequent holds in the cycle after the antecedent.
`define MWMR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mwmr: assertion failed");

// Check that an expression holds at every clock edge.
`define MWMR_ASSERT_NOW(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("mwmr: assertion failed");

`endif

// ----- src/mwmr_pkg.sv -----
package mwmr_pkg;

  localparam int unsigned DATA_W          = 32;
  localparam int unsigned RES_W           = 33;
  localparam int unsigned ADDR_W          = 5;
  localparam int unsigned MAX_COLUMNS_DEF = 1024;
  localparam int unsigned MAX_HALF_DEF    = 7;

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_HALF_W = 3'd1,
    REG_HALF_H = 3'd2,
    REG_COLS   = 3'd3,
    REG_ROWS   = 3'd4,
    REG_NODATA = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic                     operation;
    logic signed [DATA_W-1:0] pixel_value;
  } in_item_t;

  typedef struct packed {
    logic signed [RES_W-1:0] result_value;
    logic                    is_nodata;
    logic                    last_of_frame;
  } out_item_t;

  typedef struct packed {
    logic              mode;
    logic [2:0]        half_w;
    logic [2:0]        half_h;
    logic [10:0]       cols;
    logic [15:0]       rows;
    logic [DATA_W-1:0] nodata;
  } cfg_t;

  typedef struct packed {
    logic take;
    logic rd_centre;
    logic chk_centre;
    logic scan_init;
    logic scan_step;
    logic div_start;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic ready;
    logic centre_nodata;
    logic scan_last;
    logic div_busy;
    logic out_free;
    logic mode;
  } dp_status_t;

endpackage

// ----- src/mwmr_regs.sv -----
module mwmr_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mwmr_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output mwmr_pkg::cfg_t                cfg_o,
  output logic                          restart_o
);
  import mwmr_pkg::*;

  cfg_t       cfg_q;
  logic       wr;
  logic [2:0] idx;

  assign wr        = psel && penable && pwrite;
  assign idx       = paddr[4:2];
  assign pready    = 1'b1;
  assign cfg_o     = cfg_q;
  // restart the frame on any write to a known register
  assign restart_o = wr && (idx <= REG_NODATA);

  // hold the registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode   <= 1'b0;
      cfg_q.half_w <= 3'd1;
      cfg_q.half_h <= 3'd1;
      cfg_q.cols   <= 11'd1024;
      cfg_q.rows   <= 16'd1024;
      cfg_q.nodata <= 32'h8000_0000;
    end else if (wr) begin
      unique case (idx)
        REG_MODE:   cfg_q.mode   <= pwdata[0];
        REG_HALF_W: cfg_q.half_w <= pwdata[2:0];
        REG_HALF_H: cfg_q.half_h <= pwdata[2:0];
        REG_COLS:   cfg_q.cols   <= pwdata[10:0];
        REG_ROWS:   cfg_q.rows   <= pwdata[15:0];
        REG_NODATA: cfg_q.nodata <= pwdata;
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (idx)
      REG_MODE:   prdata = {31'd0, cfg_q.mode};
      REG_HALF_W: prdata = {29'd0, cfg_q.half_w};
      REG_HALF_H: prdata = {29'd0, cfg_q.half_h};
      REG_COLS:   prdata = {21'd0, cfg_q.cols};
      REG_ROWS:   prdata = {16'd0, cfg_q.rows};
      REG_NODATA: prdata = cfg_q.nodata;
      default:    prdata = 32'd0;
    endcase
  end

endmodule

// ----- src/mwmr_ctrl.sv -----
module mwmr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  mwmr_pkg::dp_status_t status_i,
  output mwmr_pkg::dp_cmd_t    cmd_o
);
  import mwmr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_CHECK, S_SCAN, S_FLUSH, S_DIVS, S_DIVW, S_OUTP
  } state_e;

  state_e state_q;

  assign in_stall_o = (state_q != S_IDLE);

  // issue datapath commands for the current step
  always_comb begin
    cmd_o            = '0;
    cmd_o.take       = in_valid_i && (state_q == S_IDLE);
    cmd_o.rd_centre  = (state_q == S_EVAL) && status_i.ready;
    cmd_o.chk_centre = (state_q == S_CHECK);
    cmd_o.scan_init  = (state_q == S_CHECK) && !status_i.centre_nodata;
    cmd_o.scan_step  = (state_q == S_SCAN);
    cmd_o.div_start  = (state_q == S_DIVS);
    cmd_o.out_load   = (state_q == S_OUTP) && status_i.out_free;
  end

  // advance the sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE:  if (in_valid_i) state_q <= S_EVAL;
        S_EVAL:  state_q <= status_i.ready ? S_CHECK : S_IDLE;
        S_CHECK: state_q <= status_i.centre_nodata ? S_OUTP : S_SCAN;
        S_SCAN:  if (status_i.scan_last) state_q <= S_FLUSH;
        S_FLUSH: state_q <= status_i.mode ? S_OUTP : S_DIVS;
        S_DIVS:  state_q <= S_DIVW;
        S_DIVW:  if (!status_i.div_busy) state_q <= S_OUTP;
        S_OUTP:  if (status_i.out_free) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/mwmr_datapath.sv -----
module mwmr_datapath #(
  parameter int unsigned MAX_COLUMNS     = mwmr_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned MAX_HALF_WINDOW = mwmr_pkg::MAX_HALF_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mwmr_pkg::cfg_t        cfg_i,
  input  logic                  restart_i,
  input  mwmr_pkg::in_item_t    in_data_i,
  input  mwmr_pkg::dp_cmd_t     cmd_i,
  output mwmr_pkg::dp_status_t  status_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output mwmr_pkg::out_item_t   out_data_o
);
  import mwmr_pkg::*;

  localparam int unsigned RING  = 2 * MAX_HALF_WINDOW + 2;
  localparam int unsigned RW    = $clog2(RING);
  localparam int unsigned IDX_W = $clog2(MAX_COLUMNS);
  localparam int unsigned COL_W = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned HW_W  = $clog2(MAX_HALF_WINDOW + 1);
  localparam int unsigned WIN   = (2 * MAX_HALF_WINDOW + 1) * (2 * MAX_HALF_WINDOW + 1);
  localparam int unsigned CNT_W = $clog2(WIN + 1);
  localparam int unsigned SUM_W = DATA_W + CNT_W;
  localparam int unsigned DC_W  = $clog2(SUM_W + 1);

  function automatic logic [RW-1:0] ring_inc(input logic [RW-1:0] x);
    ring_inc = (x == RW'(RING - 1)) ? '0 : RW'(x + 1'b1);
  endfunction

  // line ring
  logic [DATA_W-1:0] mem_q [RING][MAX_COLUMNS];
  logic [DATA_W-1:0] rd_q;
  logic [RW-1:0]     ra_ring;
  logic [COL_W-1:0]  ra_col;

  // position counters
  logic [15:0]      in_row_q, out_row_q;
  logic [COL_W-1:0] in_col_q, out_col_q;
  logic [RW-1:0]    in_ring_q, out_ring_q;

  // scan counters
  logic [15:0]      sr_q;
  logic [COL_W-1:0] sc_q;
  logic [RW-1:0]    sring_q;

  // accumulators and divider
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [DATA_W-1:0] mn_q, mx_q;
  logic [CNT_W-1:0]         cnt_q;
  logic                     acc_v_q;
  logic                     nodata_q;
  logic [SUM_W-1:0]         dv_mag_q;
  logic [CNT_W:0]           dv_rem_q;
  logic [DC_W-1:0]          dv_cnt_q;
  logic                     dv_neg_q;
  logic [CNT_W:0]           rem_sh;
  logic                     ge;

  logic                out_valid_q;
  out_item_t           out_q;

  // effective configuration
  logic [COL_W-1:0]  cols_eff, cols_m1;
  logic [15:0]       rows_eff, rows_m1;
  logic [HW_W-1:0]   hw_eff, hh_eff;
  logic [16:0]       need_r_sum;
  logic [COL_W:0]    need_c_sum;
  logic [15:0]       need_r, r0;
  logic [COL_W-1:0]  need_c, c0;
  logic [RW-1:0]     dr, ring0;
  logic              push, last, rd_nodata;
  logic signed [DATA_W-1:0] rd_s;
  logic signed [RES_W-1:0]  mean_v, range_v;

  always_comb begin
    if (cfg_i.cols == 11'd0) begin
      cols_eff = COL_W'(1);
    end else if (32'(cfg_i.cols) > MAX_COLUMNS) begin
      cols_eff = COL_W'(MAX_COLUMNS);
    end else begin
      cols_eff = COL_W'(cfg_i.cols);
    end
    rows_eff = (cfg_i.rows == 16'd0) ? 16'd1 : cfg_i.rows;
    hw_eff = (32'(cfg_i.half_w) > MAX_HALF_WINDOW) ? HW_W'(MAX_HALF_WINDOW)
                                                    : HW_W'(cfg_i.half_w);
    hh_eff = (32'(cfg_i.half_h) > MAX_HALF_WINDOW) ? HW_W'(MAX_HALF_WINDOW)
                                                    : HW_W'(cfg_i.half_h);
    cols_m1 = cols_eff - 1'b1;
    rows_m1 = rows_eff - 1'b1;
  end

  // window bounds around the output cell
  always_comb begin
    need_r_sum = 17'(out_row_q) + 17'(hh_eff);
    need_r     = (need_r_sum > 17'(rows_m1)) ? rows_m1 : need_r_sum[15:0];
    need_c_sum = (COL_W + 1)'(out_col_q) + (COL_W + 1)'(hw_eff);
    need_c     = (need_c_sum > (COL_W + 1)'(cols_m1)) ? cols_m1 : need_c_sum[COL_W-1:0];
    r0 = (out_row_q >= 16'(hh_eff)) ? out_row_q - 16'(hh_eff) : 16'd0;
    c0 = (out_col_q >= COL_W'(hw_eff)) ? out_col_q - COL_W'(hw_eff) : '0;
    dr = RW'(out_row_q - r0);
    ring0 = (out_ring_q >= dr) ? RW'(out_ring_q - dr)
                               : RW'(int'(out_ring_q) + RING - int'(dr));
  end

  assign push      = cmd_i.take && !in_data_i.operation && (in_row_q < rows_eff);
  assign last      = (out_row_q == rows_m1) && (out_col_q == cols_m1);
  assign rd_s      = signed'(rd_q);
  assign rd_nodata = (rd_q == cfg_i.nodata);

  assign status_o.ready = (in_row_q > need_r) || ((in_row_q == need_r) && (in_col_q > need_c));
  assign status_o.centre_nodata = rd_nodata;
  assign status_o.scan_last     = (sr_q == need_r) && (sc_q == need_c);
  assign status_o.div_busy      = (dv_cnt_q != '0);
  assign status_o.out_free      = !out_valid_q || !out_stall_i;
  assign status_o.mode          = cfg_i.mode;

  // select the read address
  assign ra_ring = cmd_i.rd_centre ? out_ring_q : sring_q;
  assign ra_col  = cmd_i.rd_centre ? out_col_q : sc_q;

  // write and read the line ring
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[in_ring_q][in_col_q[IDX_W-1:0]] <= in_data_i.pixel_value;
    end
    rd_q <= mem_q[ra_ring][ra_col[IDX_W-1:0]];
  end

  // advance the position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q   <= '0;
      in_col_q   <= '0;
      in_ring_q  <= '0;
      out_row_q  <= '0;
      out_col_q  <= '0;
      out_ring_q <= '0;
    end else if (restart_i || (cmd_i.out_load && last)) begin
      in_row_q   <= '0;
      in_col_q   <= '0;
      in_ring_q  <= '0;
      out_row_q  <= '0;
      out_col_q  <= '0;
      out_ring_q <= '0;
    end else begin
      if (push) begin
        if (in_col_q + 1'b1 >= cols_eff) begin
          in_col_q  <= '0;
          in_row_q  <= in_row_q + 1'b1;
          in_ring_q <= ring_inc(in_ring_q);
        end else begin
          in_col_q <= in_col_q + 1'b1;
        end
      end
      if (cmd_i.out_load) begin
        if (out_col_q + 1'b1 >= cols_eff) begin
          out_col_q  <= '0;
          out_row_q  <= out_row_q + 1'b1;
          out_ring_q <= ring_inc(out_ring_q);
        end else begin
          out_col_q <= out_col_q + 1'b1;
        end
      end
    end
  end

  // step through the window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_v_q <= 1'b0;
    end else begin
      acc_v_q <= cmd_i.scan_step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      sr_q    <= r0;
      sc_q    <= c0;
      sring_q <= ring0;
    end else if (cmd_i.scan_step) begin
      if (sc_q == need_c) begin
        sc_q    <= c0;
        sr_q    <= sr_q + 1'b1;
        sring_q <= ring_inc(sring_q);
      end else begin
        sc_q <= sc_q + 1'b1;
      end
    end
  end

  // accumulate valid window cells
  always_ff @(posedge clk_i) begin
    if (cmd_i.chk_centre) begin
      nodata_q <= rd_nodata;
    end
    if (cmd_i.scan_init) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else if (acc_v_q && !rd_nodata) begin
      sum_q <= sum_q + SUM_W'(rd_s);
      cnt_q <= cnt_q + 1'b1;
      if ((cnt_q == '0) || (rd_s < mn_q)) mn_q <= rd_s;
      if ((cnt_q == '0) || (rd_s > mx_q)) mx_q <= rd_s;
    end
  end

  // divide the sum by the count, one quotient bit a cycle
  assign rem_sh = {dv_rem_q[CNT_W-1:0], dv_mag_q[SUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, cnt_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      dv_cnt_q <= DC_W'(SUM_W);
    end else if (dv_cnt_q != '0) begin
      dv_cnt_q <= dv_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dv_neg_q <= sum_q[SUM_W-1];
      dv_mag_q <= sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
      dv_rem_q <= '0;
    end else if (dv_cnt_q != '0) begin
      dv_rem_q <= ge ? rem_sh - {1'b0, cnt_q} : rem_sh;
      dv_mag_q <= {dv_mag_q[SUM_W-2:0], ge};
    end
  end

  assign mean_v  = dv_neg_q ? RES_W'(-dv_mag_q) : RES_W'(dv_mag_q);
  assign range_v = RES_W'(mx_q) - RES_W'(mn_q);

  // hold the result item until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.result_value  <= nodata_q ? '0 : (cfg_i.mode ? range_v : mean_v);
      out_q.is_nodata     <= nodata_q;
      out_q.last_of_frame <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- src/moving_window_mean_range_filter.sv -----
// Channel  Direction  Handshake                     Payload
// input    in         in_valid_i / in_stall_o       in_data_i  (operation, pixel_value)
// output   out        out_valid_o / out_stall_i     out_data_o (result_value, is_nodata,
//                                                              last_of_frame)
// config   in         psel/penable/pwrite/pready    paddr, pwdata, prdata
//
// An item without a result is only evaluated; one with a nodata centre goes from the
// centre check to output. Any other item scans its clipped window cells, one line-ring
// read port serving one cell a cycle, and the mean uses a radix-2 divider (SUM_W = 32
// + bits of the largest window count). Reset clears the position and divider counters
// and the sequencer; the line ring needs no clearing pass. A stalled result stays in
// the output register while the next item is taken; that item's result waits for it.
module moving_window_mean_range_filter #(
  parameter int unsigned MAX_COLUMNS     = mwmr_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned MAX_HALF_WINDOW = mwmr_pkg::MAX_HALF_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  mwmr_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output mwmr_pkg::out_item_t           out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mwmr_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import mwmr_pkg::*;

  cfg_t       cfg;
  logic       restart;
  dp_cmd_t    cmd;
  dp_status_t status;

  mwmr_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg), .restart_o(restart)
  );

  mwmr_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .status_i(status), .cmd_o(cmd)
  );

  mwmr_datapath #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_HALF_WINDOW(MAX_HALF_WINDOW)
  ) u_dp (
    .clk_i, .rst_ni, .cfg_i(cfg), .restart_i(restart), .in_data_i, .cmd_i(cmd),
    .status_o(status), .out_valid_o, .out_stall_i, .out_data_o
  );

endmodule

// ----- src/mwmr_checker.sv -----
`include "moving_window_mean_range_filter_macros.svh"

module mwmr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input mwmr_pkg::out_item_t           out_data_o,
  input logic                          pready
);
  import mwmr_pkg::*;

  // hold a stalled result item
  `MWMR_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))
  // go busy after taking an item
  `MWMR_ASSERT_NEXT(a_busy_after_take, in_valid_i && !in_stall_o, in_stall_o)
  // nodata results carry a zero value
  `MWMR_ASSERT_NOW(a_nodata_zero, !(out_valid_o && out_data_o.is_nodata) || (out_data_o.result_value == '0))
  // config port never waits
  `MWMR_ASSERT_NOW(a_pready, pready)

endmodule

bind moving_window_mean_range_filter mwmr_checker u_chk (.*);
